@@ hw/rtl/krq_pkg.sv @@
// Package for the keyed retransmit queue: field widths, operation and status codes,
// the entry type and the control bundle that drives each queue cell.
// No dependencies.
package krq_pkg;

    localparam int SEQ_W     = 16;
    localparam int TIME_W    = 32;
    localparam int ELAPSED_W = TIME_W + 1;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_LOOKUP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] send_time;
        logic [TIME_W-1:0] timeout;
    } entry_t;

    // Broadcast to every cell; occupied and tail are worked out per cell.
    typedef struct packed {
        logic             eval;
        logic             commit;
        mode_t            mode;
        logic [SEQ_W-1:0] key;
        logic             occupied;
        logic             tail;
    } cell_ctl_t;

endpackage

@@ hw/rtl/krq_ifs.sv @@
// Handshake channels of the keyed retransmit queue: request and response.
// Depends on krq_pkg for the field widths.
interface krq_req_if
    import krq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [SEQ_W-1:0]  seq_num;
    logic [TIME_W-1:0] send_time;
    logic [TIME_W-1:0] timeout_value;

    modport source (output valid, output mode, output seq_num, output send_time,
                    output timeout_value, input ready);
    modport sink   (input valid, input mode, input seq_num, input send_time,
                    input timeout_value, output ready);
endinterface

interface krq_rsp_if
    import krq_pkg::*;
#(
    parameter int OCC_W = 5
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic signed [ELAPSED_W-1:0] elapsed;
    logic [OCC_W-1:0]            occupancy;

    modport source (output valid, output status, output elapsed, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input elapsed, input occupancy,
                    output ready);
endinterface

@@ hw/rtl/krq_cell.sv @@
// One queue cell: holds a single entry, loaded by a push at the tail, compares it with
// the broadcast key and takes its neighbour's entry when a gap closes. Depends on krq_pkg.
module krq_cell
    import krq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      seen_in,
    output logic      seen_out,
    input  entry_t    next_entry,
    input  entry_t    new_entry,
    output entry_t    entry,
    output logic      hit
);

    entry_t entry_reg;
    logic   hit_reg;
    logic   shift_reg;
    logic   load_reg;
    logic   match;

    // A cell is the oldest match when it matches and no earlier cell did.
    assign match    = ctl.occupied && (entry_reg.seq == ctl.key);
    assign seen_out = seen_in | match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            shift_reg <= 1'b0;
            load_reg  <= 1'b0;
        end
        else if (ctl.eval)
        begin
            hit_reg   <= (ctl.mode == MODE_LOOKUP) && match && !seen_in;
            shift_reg <= ((ctl.mode == MODE_POP) || (ctl.mode == MODE_REMOVE)) && seen_out;
            load_reg  <= (ctl.mode == MODE_PUSH) && ctl.tail;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            if (load_reg)
            begin
                entry_reg <= new_entry;
            end
            else if (shift_reg)
            begin
                entry_reg <= next_entry;
            end
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

@@ hw/rtl/keyed_retransmit_queue.sv @@
// Keyed retransmit queue: an ordered row of cells with push, pop, keyed removal
// and keyed lookup. Depends on krq_pkg, krq_ifs and krq_cell.
//
//   Channel  Direction  Carries
//   req      in         mode, seq_num, send_time, timeout_value
//   rsp      out        status, elapsed, occupancy
//
// At acceptance all cells compare the key in parallel and register whether they
// shift, load or hit; in the execute state the cells commit once the result
// register is free, and the result is registered. One request is in flight at a time.
// The result register lets the next request be accepted while a result waits;
// a stalled response holds the execute state until the register frees.
// Reset empties the queue at once; entry contents are not cleared.
module keyed_retransmit_queue
    import krq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    krq_req_if.sink   req,
    krq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                      state_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_after_reg;
    status_t                     status_reg;
    entry_t                      new_entry_reg;
    logic                        rsp_valid_reg;
    status_t                     rsp_status_reg;
    logic [ELAPSED_W-1:0]        rsp_elapsed_reg;
    logic [CNT_W-1:0]            rsp_occ_reg;

    logic                        accept;
    logic                        commit;
    mode_t                       req_mode;
    status_t                     status_next;
    logic [CNT_W-1:0]            cnt_next;
    logic                        found;
    entry_t                      hit_entry;
    logic [ELAPSED_W-1:0]        elapsed_next;

    cell_ctl_t                   ctl    [DEPTH];
    entry_t                      entries[DEPTH];
    logic                        seen   [DEPTH+1];
    logic [DEPTH-1:0]            hit_vec;

    assign req_mode  = mode_t'(req.mode);
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    // A pop is an unconditional shift from the head, so its chain starts set.
    assign seen[0] = (req_mode == MODE_POP) && (cnt_reg != '0);
    assign found   = seen[DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            always_comb
            begin
                ctl[gi].eval     = accept;
                ctl[gi].commit   = commit;
                ctl[gi].mode     = req_mode;
                ctl[gi].key      = req.seq_num;
                ctl[gi].occupied = (cnt_reg > CNT_W'(gi));
                ctl[gi].tail     = (cnt_reg == CNT_W'(gi));
            end

            krq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[gi]),
                .seen_in   (seen[gi]),
                .seen_out  (seen[gi+1]),
                .next_entry(entries[(gi == DEPTH - 1) ? gi : gi + 1]),
                .new_entry (new_entry_reg),
                .entry     (entries[gi]),
                .hit       (hit_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        status_next = ST_OK;
        cnt_next    = cnt_reg;
        case (req_mode)
            MODE_PUSH:
            begin
                if (cnt_reg == CNT_W'(DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MODE_POP:
            begin
                if (cnt_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MODE_REMOVE, MODE_LOOKUP:
            begin
                if (cnt_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else if (req_mode == MODE_REMOVE)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // At most one cell hits, so an OR across the row selects its entry.
    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit_vec[i])
            begin
                hit_entry = hit_entry | entries[i];
            end
        end
    end

    assign elapsed_next = {1'b0, hit_entry.send_time} - {1'b0, hit_entry.timeout};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            cnt_after_reg   <= '0;
            status_reg      <= ST_OK;
            new_entry_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_status_reg  <= ST_OK;
            rsp_elapsed_reg <= '0;
            rsp_occ_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        new_entry_reg <= '{seq: req.seq_num, send_time: req.send_time,
                                           timeout: req.timeout_value};
                        status_reg    <= status_next;
                        cnt_after_reg <= cnt_next;
                        state_reg     <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        cnt_reg         <= cnt_after_reg;
                        rsp_status_reg  <= status_reg;
                        rsp_elapsed_reg <= elapsed_next;
                        rsp_occ_reg     <= cnt_after_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.elapsed   = rsp_elapsed_reg;
    assign rsp.occupancy = rsp_occ_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell reports the oldest match");

    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised without a committed transaction");

    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg == ST_FULL)) |-> (rsp_occ_reg == CNT_W'(DEPTH)))
        else $error("dropped push reported with a queue that is not full");

    a_elapsed_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg != ST_OK)) |-> (rsp_elapsed_reg == '0))
        else $error("elapsed time reported for a failed transaction");
`endif

endmodule

@@ tb/sv/tb_keyed_retransmit_queue.sv @@
// Self-checking testbench for keyed_retransmit_queue: directed and random request
// transactions, a scoreboard class that predicts every response and checks it.
// Depends on krq_pkg, krq_ifs and the keyed_retransmit_queue RTL.
`timescale 1ns / 1ps

module tb_keyed_retransmit_queue;
    import krq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int OCC_W        = 5;
    localparam int IDLE_PCT     = 26;
    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        status_t                     status;
        logic signed [ELAPSED_W-1:0] elapsed;
        logic [OCC_W-1:0]            occupancy;
    } krq_result_t;

    // Mirror of the queue contents plus the responses still owed by the block.
    class krq_scoreboard;
        entry_t      cells[DEPTH];
        int unsigned count;
        krq_result_t pending_q[$];
        int unsigned errors;
        int unsigned reports;
        int unsigned checked;
        int unsigned lookup_hits;
        int unsigned mode_seen[4];
        int unsigned status_seen[4];

        function new();
            count       = 0;
            errors      = 0;
            reports     = 0;
            checked     = 0;
            lookup_hits = 0;
            foreach (mode_seen[i]) mode_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int oldest_match(logic [SEQ_W-1:0] key);
            for (int i = 0; i < count; i++)
            begin
                if (cells[i].seq == key)
                    return i;
            end
            return -1;
        endfunction

        // Later entries move up one place so that arrival order is kept.
        function void close_gap(int pos);
            for (int i = pos; i + 1 < count; i++)
                cells[i] = cells[i + 1];
            count--;
        endfunction

        function logic [SEQ_W-1:0] stored_key();
            return cells[$urandom_range(count - 1)].seq;
        endfunction

        function void note_request(mode_t m, logic [SEQ_W-1:0] key,
                                   logic [TIME_W-1:0] t, logic [TIME_W-1:0] to);
            krq_result_t r;
            int          pos;
            r.status  = ST_OK;
            r.elapsed = '0;
            if (m == MODE_PUSH)
            begin
                if (count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    cells[count].seq       = key;
                    cells[count].send_time = t;
                    cells[count].timeout   = to;
                    count++;
                end
            end
            else if (count == 0)
                r.status = ST_EMPTY;
            else if (m == MODE_POP)
                close_gap(0);
            else
            begin
                pos = oldest_match(key);
                if (pos < 0)
                    r.status = ST_NOT_FOUND;
                else if (m == MODE_REMOVE)
                    close_gap(pos);
                else
                begin
                    // Widened by one bit, so the difference is exact.
                    r.elapsed = {1'b0, cells[pos].send_time} - {1'b0, cells[pos].timeout};
                    lookup_hits++;
                end
            end
            r.occupancy = OCC_W'(count);
            mode_seen[m]++;
            status_seen[r.status]++;
            pending_q.push_back(r);
        endfunction

        function void report(string msg);
            errors++;
            if (reports < 200)
                $display("%0t: %s", $time, msg);
            else if (reports == 200)
                $display("%0t: further mismatch reports suppressed", $time);
            reports++;
        endfunction

        function void check_response(logic [1:0] st, logic signed [ELAPSED_W-1:0] el,
                                     logic [OCC_W-1:0] occ);
            krq_result_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf({"unexpected response: expected none, ",
                                  "got status %0d elapsed %0d occupancy %0d"},
                                 st, el, occ));
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (st !== want.status)
                report($sformatf("status: expected %0d, got %0d", want.status, st));
            if (el !== want.elapsed)
                report($sformatf("elapsed: expected %0d, got %0d", want.elapsed, el));
            if (occ !== want.occupancy)
                report($sformatf("occupancy: expected %0d, got %0d", want.occupancy, occ));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;

    krq_req_if                     req_ch();
    krq_rsp_if #(.OCC_W(OCC_W))    rsp_ch();

    keyed_retransmit_queue #(.DEPTH(DEPTH)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    krq_scoreboard   sb = new();
    logic [SEQ_W-1:0] key_pool[8];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drives one request and returns at the edge where it is accepted.
    task automatic send_request(input mode_t m, input logic [SEQ_W-1:0] key,
                                input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] to);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= m;
        req_ch.seq_num       <= key;
        req_ch.send_time     <= t;
        req_ch.timeout_value <= to;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(m, key, t, to);
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic run_directed();
        // Operations on an empty queue.
        send_request(MODE_POP,    16'h5a5a, $urandom, $urandom);
        send_request(MODE_REMOVE, 16'hffff, $urandom, $urandom);
        send_request(MODE_LOOKUP, 16'h0000, $urandom, $urandom);
        // Fill to the brim with extreme times and a duplicated key, then push once more.
        send_request(MODE_PUSH, 16'h0000, 32'h0000_0000, 32'hffff_ffff);
        send_request(MODE_PUSH, 16'hffff, 32'hffff_ffff, 32'h0000_0000);
        send_request(MODE_PUSH, 16'h1234, 32'h0001_8000, 32'h0000_4000);
        send_request(MODE_PUSH, 16'h00ff, 32'h8000_0000, 32'h8000_0000);
        send_request(MODE_PUSH, 16'h1234, 32'h0000_4000, 32'h0001_8000);
        for (int i = 5; i < DEPTH; i++)
            send_request(MODE_PUSH, SEQ_W'(16'h7700 + i), $urandom, $urandom);
        send_request(MODE_PUSH, 16'haaaa, 32'h5555_5555, 32'haaaa_aaaa);
        // Lookups: oldest duplicate, most negative, most positive, a miss; then a removal that misses.
        send_request(MODE_LOOKUP, 16'h1234, $urandom, $urandom);
        send_request(MODE_LOOKUP, 16'h0000, $urandom, $urandom);
        send_request(MODE_LOOKUP, 16'hffff, $urandom, $urandom);
        send_request(MODE_LOOKUP, 16'hbeef, $urandom, $urandom);
        send_request(MODE_REMOVE, 16'hbeef, $urandom, $urandom);
        // Removing the older duplicate leaves the younger one visible.
        send_request(MODE_REMOVE, 16'h1234, $urandom, $urandom);
        send_request(MODE_LOOKUP, 16'h1234, $urandom, $urandom);
        send_request(MODE_POP,    16'h0000, $urandom, $urandom);
    endtask

    task automatic run_random();
        mode_t            m;
        logic [SEQ_W-1:0] key;
        int               push_w;
        int               sel;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 500 && n < 800);
            // Rotate between filling, balanced and draining phases.
            case ((n / 100) % 3)
                0:       push_w = 65;
                1:       push_w = 40;
                default: push_w = 15;
            endcase
            if ($urandom_range(99) < push_w)
                m = MODE_PUSH;
            else
            begin
                sel = $urandom_range(2);
                m = (sel == 0) ? MODE_POP : (sel == 1) ? MODE_REMOVE : MODE_LOOKUP;
            end
            if ((m == MODE_REMOVE || m == MODE_LOOKUP) && sb.count > 0
                && $urandom_range(99) < 65)
                key = sb.stored_key();
            else if ($urandom_range(99) < 80)
                key = key_pool[$urandom_range(7)];
            else
                key = SEQ_W'($urandom);
            send_request(m, key, pick_time(), pick_time());
        end
        steady = 1'b0;
        req_ch.valid <= 1'b0;
    endtask

    // Response side: random back-pressure, every accepted transaction is checked.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.elapsed, rsp_ch.occupancy);
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Ends the run if neither channel moves a transaction for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        steady               = 1'b0;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.mode          <= MODE_PUSH;
        req_ch.seq_num       <= '0;
        req_ch.send_time     <= '0;
        req_ch.timeout_value <= '0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hffff;
        for (int i = 2; i < 8; i++)
            key_pool[i] = SEQ_W'($urandom);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d push, %0d pop, %0d remove, %0d lookup (%0d hits)",
                 sb.mode_seen[MODE_PUSH], sb.mode_seen[MODE_POP], sb.mode_seen[MODE_REMOVE],
                 sb.mode_seen[MODE_LOOKUP], sb.lookup_hits);
        $display("%0d responses checked; outcomes: %0d ok, %0d full, %0d empty, %0d not found",
                 sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOT_FOUND]);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
